>>> rtl/spd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg: shared types and codes of the sync packet receiver
// Register indexes, message types, mode request codes and the packet
// descriptor that travels from the deframer to the decoder.
// ----------------------------------------------------------------------------
package spd_pkg;

    // configuration register indexes
    localparam logic CFG_SYNC_HIGH = 1'b0;
    localparam logic CFG_SYNC_LOW  = 1'b1;

    localparam logic [7:0] SYNC_HIGH_RESET = 8'hBE;
    localparam logic [7:0] SYNC_LOW_RESET  = 8'hEF;

    // message types
    localparam logic [7:0] TYPE_ACK      = 8'h00;
    localparam logic [7:0] TYPE_SAFE     = 8'h02;
    localparam logic [7:0] TYPE_FOLLOW   = 8'h04;
    localparam logic [7:0] TYPE_SET_MODE = 8'h05;

    // offset-4 argument values
    localparam logic [7:0] ARG_CRUISE = 8'h00;
    localparam logic [7:0] ARG_IDLE   = 8'h01;
    localparam logic [7:0] ARG_SAFE   = 8'h02;
    localparam logic [7:0] ARG_ACK_IDLE = 8'h04;

    // mode request codes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_IDLE   = 2'd1;
    localparam logic [1:0] MODE_CRUISE = 2'd2;
    localparam logic [1:0] MODE_SAFE   = 2'd3;

    // one finished packet, as seen on its last byte
    typedef struct packed {
        logic [7:0] packet_type;
        logic [7:0] payload_length;
        logic [7:0] offset4_byte;
        logic [7:0] offset5_byte;
        logic       checksum_ok;
        logic       not_above_idle;
        logic       is_cruise;
    } spd_desc_t;

    // write side of the descriptor queue
    typedef struct packed {
        logic      push;
        spd_desc_t desc;
    } spd_push_t;

endpackage

`default_nettype wire

>>> rtl/spd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_front: sync hunt, field capture and checksum
// Takes one link byte per accepted word and pushes a descriptor on the
// checksum low byte.
// ----------------------------------------------------------------------------
module spd_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             cfg_addr,
    input  wire logic [7:0]       cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_rx_byte,
    input  wire logic             s_state_not_above_idle,
    input  wire logic             s_state_is_cruise,
    input  wire logic             q_full,
    output spd_pkg::spd_push_t    q_wr
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CK_HI   = 3'd5,
        PH_CK_LO   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] sum_reg, sum_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  sync_high_reg, sync_low_reg;
    logic [7:0]  type_reg, len_reg, b4_reg, b5_reg, ck_hi_reg;
    logic [7:0]  b4_now, b5_now;
    logic        accept;
    logic        capturing;

    // high += byte; low += high (both mod 256)
    function automatic logic [15:0] sum_add(input logic [15:0] s, input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = s[15:8] + b;
        lo = s[7:0] + hi;
        return {hi, lo};
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign capturing = (phase_reg == PH_TYPE) || (phase_reg == PH_LEN) ||
                       (phase_reg == PH_PAYLOAD) || (phase_reg == PH_CK_HI) ||
                       (phase_reg == PH_CK_LO);

    // bypass so the byte landing at offset 4/5 on this word is seen now
    assign b4_now = (capturing && pos_reg == 9'd4) ? s_rx_byte : b4_reg;
    assign b5_now = (capturing && pos_reg == 9'd5) ? s_rx_byte : b5_reg;

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        pos_next   = capturing ? pos_reg + 9'd1 : pos_reg;
        case (phase_reg)
            PH_SYNC2: begin
                if (s_rx_byte == sync_low_reg) begin
                    sum_next   = sum_add(sum_add(16'd0, sync_high_reg), sync_low_reg);
                    pos_next   = 9'd2;
                    phase_next = PH_TYPE;
                end else if (s_rx_byte != sync_high_reg) begin
                    phase_next = PH_HUNT;
                end
            end
            PH_TYPE: begin
                sum_next   = sum_add(sum_reg, s_rx_byte);
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                sum_next   = sum_add(sum_reg, s_rx_byte);
                phase_next = (s_rx_byte == 8'd0) ? PH_CK_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                sum_next = sum_add(sum_reg, s_rx_byte);
                if (pos_next == {1'b0, len_reg} + 9'd4) begin
                    phase_next = PH_CK_HI;
                end
            end
            PH_CK_HI: begin
                phase_next = PH_CK_LO;
            end
            PH_CK_LO: begin
                phase_next = PH_HUNT;
            end
            default: begin
                phase_next = (s_rx_byte == sync_high_reg) ? PH_SYNC2 : PH_HUNT;
            end
        endcase
    end

    always_comb begin
        q_wr.push                = accept && (phase_reg == PH_CK_LO);
        q_wr.desc.packet_type    = type_reg;
        q_wr.desc.payload_length = len_reg;
        q_wr.desc.offset4_byte   = b4_now;
        q_wr.desc.offset5_byte   = b5_now;
        q_wr.desc.checksum_ok    = ({ck_hi_reg, s_rx_byte} == sum_reg);
        q_wr.desc.not_above_idle = s_state_not_above_idle;
        q_wr.desc.is_cruise      = s_state_is_cruise;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            sum_reg       <= 16'd0;
            pos_reg       <= 9'd0;
            sync_high_reg <= spd_pkg::SYNC_HIGH_RESET;
            sync_low_reg  <= spd_pkg::SYNC_LOW_RESET;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    spd_pkg::CFG_SYNC_HIGH: sync_high_reg <= cfg_wdata;
                    spd_pkg::CFG_SYNC_LOW:  sync_low_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                pos_reg   <= pos_next;
                b4_reg    <= b4_now;
                b5_reg    <= b5_now;
                if (phase_reg == PH_TYPE) type_reg  <= s_rx_byte;
                if (phase_reg == PH_LEN)  len_reg   <= s_rx_byte;
                if (phase_reg == PH_CK_HI) ck_hi_reg <= s_rx_byte;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/spd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_queue: descriptor queue between deframer and decoder
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module spd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire spd_pkg::spd_push_t wr,
    output logic                    full,
    input  wire logic               pop,
    output spd_pkg::spd_desc_t      rd_desc,
    output logic                    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    spd_pkg::spd_desc_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = wr.push && !full;
    assign do_pop  = pop && !empty;
    assign rd_desc = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wr.desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/spd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_back: command decode and result register
// Pops one descriptor, decodes the mode request, holds the result word.
// ----------------------------------------------------------------------------
module spd_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire spd_pkg::spd_desc_t q_desc,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_packet_type,
    output logic [7:0]             m_payload_length,
    output logic [7:0]             m_offset4_byte,
    output logic [7:0]             m_offset5_byte,
    output logic                   m_checksum_ok,
    output logic                   m_ack_seen,
    output logic [1:0]             m_mode_request
);

    logic       valid_reg;
    logic [7:0] type_reg, len_reg, b4_reg, b5_reg;
    logic       ok_reg, ack_reg;
    logic [1:0] mode_reg;
    logic [1:0] mode_dec;

    assign q_pop = !q_empty && (!valid_reg || m_ready);

    always_comb begin
        mode_dec = spd_pkg::MODE_NONE;
        if (q_desc.checksum_ok) begin
            case (q_desc.packet_type)
                spd_pkg::TYPE_ACK: begin
                    if (q_desc.offset4_byte == spd_pkg::ARG_ACK_IDLE) begin
                        mode_dec = spd_pkg::MODE_IDLE;
                    end
                end
                spd_pkg::TYPE_SAFE: mode_dec = spd_pkg::MODE_SAFE;
                spd_pkg::TYPE_FOLLOW: begin
                    if (q_desc.not_above_idle) begin
                        mode_dec = spd_pkg::MODE_IDLE;
                    end else if (q_desc.is_cruise) begin
                        mode_dec = spd_pkg::MODE_CRUISE;
                    end
                end
                spd_pkg::TYPE_SET_MODE: begin
                    case (q_desc.offset4_byte)
                        spd_pkg::ARG_CRUISE: mode_dec = spd_pkg::MODE_CRUISE;
                        spd_pkg::ARG_IDLE:   mode_dec = spd_pkg::MODE_IDLE;
                        spd_pkg::ARG_SAFE:   mode_dec = spd_pkg::MODE_SAFE;
                        default:             mode_dec = spd_pkg::MODE_NONE;
                    endcase
                end
                default: mode_dec = spd_pkg::MODE_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            type_reg <= q_desc.packet_type;
            len_reg  <= q_desc.payload_length;
            b4_reg   <= q_desc.offset4_byte;
            b5_reg   <= q_desc.offset5_byte;
            ok_reg   <= q_desc.checksum_ok;
            ack_reg  <= q_desc.checksum_ok && (q_desc.packet_type == spd_pkg::TYPE_ACK);
            mode_reg <= mode_dec;
        end
    end

    assign m_valid          = valid_reg;
    assign m_packet_type    = type_reg;
    assign m_payload_length = len_reg;
    assign m_offset4_byte   = b4_reg;
    assign m_offset5_byte   = b5_reg;
    assign m_checksum_ok    = ok_reg;
    assign m_ack_seen       = ack_reg;
    assign m_mode_request   = mode_reg;

endmodule

`default_nettype wire

>>> rtl/sync_packet_receiver_dispatch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_packet_receiver_dispatch: sync-word packet deframer and dispatcher
// Hunts for a two-byte sync word, checks a Fletcher-style 16-bit sum and
// emits one decoded result word per received packet.
// ----------------------------------------------------------------------------
// One link byte is taken per input word, and the block takes one word every
// clock as long as the descriptor queue has room; s_ready drops only while
// the queue is full, i.e. when results back up behind a stalled m_ready.
// Bytes that do not end a packet produce nothing. The checksum low byte of
// a packet produces one result word, through the queue write and then the
// result register. The frame is: sync high, sync low, type, length, length
// payload bytes, checksum high, checksum low. The sum runs over sync, type,
// length and payload: high += byte, low += high, both mod 256. A bad checksum
// still yields a result, with checksum_ok, ack_seen and mode_request all zero.
// Sync bytes are set through cfg_we/cfg_addr/cfg_wdata (index 0 sync high,
// index 1 sync low); the user must write them only while no packet is in
// flight, unenforced by the block. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sync_packet_receiver_dispatch #(
    parameter int QUEUE_DEPTH = 2   // descriptor queue depth, 2 or more
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration write port
    input  wire logic       cfg_we,
    input  wire logic       cfg_addr,
    input  wire logic [7:0] cfg_wdata,
    // received byte stream
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       s_state_not_above_idle,
    input  wire logic       s_state_is_cruise,
    // decoded packet results
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_packet_type,
    output logic [7:0]      m_payload_length,
    output logic [7:0]      m_offset4_byte,
    output logic [7:0]      m_offset5_byte,
    output logic            m_checksum_ok,
    output logic            m_ack_seen,
    output logic [1:0]      m_mode_request
);

    spd_pkg::spd_push_t q_wr;       // deframer -> queue
    spd_pkg::spd_desc_t q_desc;     // queue head -> decoder
    logic               q_full;
    logic               q_empty;
    logic               q_pop;

    // front: sync hunt, field capture, running sum
    spd_front u_front (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_we                 (cfg_we),
        .cfg_addr               (cfg_addr),
        .cfg_wdata              (cfg_wdata),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_rx_byte              (s_rx_byte),
        .s_state_not_above_idle (s_state_not_above_idle),
        .s_state_is_cruise      (s_state_is_cruise),
        .q_full                 (q_full),
        .q_wr                   (q_wr)
    );

    // decouples the byte stream from result back-pressure
    spd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .full    (q_full),
        .pop     (q_pop),
        .rd_desc (q_desc),
        .empty   (q_empty)
    );

    // back: mode decode and output register
    spd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_desc           (q_desc),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packet_type    (m_packet_type),
        .m_payload_length (m_payload_length),
        .m_offset4_byte   (m_offset4_byte),
        .m_offset5_byte   (m_offset5_byte),
        .m_checksum_ok    (m_checksum_ok),
        .m_ack_seen       (m_ack_seen),
        .m_mode_request   (m_mode_request)
    );

endmodule

`default_nettype wire

>>> rtl/spd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_checker: port-level checks for the sync packet receiver
// Result consistency and output handshake checks, bound to the top level.
// ----------------------------------------------------------------------------
module spd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_packet_type,
    input wire logic       m_checksum_ok,
    input wire logic       m_ack_seen,
    input wire logic [1:0] m_mode_request
);

    // no result word right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packet_type) &&
        $stable(m_mode_request))
        else $error("stalled result changed");

    // ack only on a good ack-type packet
    a_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ack_seen |-> m_checksum_ok && (m_packet_type == spd_pkg::TYPE_ACK))
        else $error("ack without good ack packet");

    // bad checksum carries no request
    a_bad_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_checksum_ok |-> (m_mode_request == spd_pkg::MODE_NONE) && !m_ack_seen)
        else $error("request on bad checksum");

endmodule

bind sync_packet_receiver_dispatch spd_checker u_spd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_packet_type  (m_packet_type),
    .m_checksum_ok  (m_checksum_ok),
    .m_ack_seen     (m_ack_seen),
    .m_mode_request (m_mode_request)
);

`default_nettype wire
